### hw/rtl/cdrm_pkg.sv
// ----------------------------------------------------------------------------
// cdrm_pkg
// Shared types and constants for the counter delta rate meter: request
// payloads, controller states, divider operations and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package cdrm_pkg;

  localparam int FIELD_W     = 64;  // width of every counter/time field
  localparam int DIV_W       = 64;  // divider operand width
  localparam int STEP_W      = 7;   // divider step counter, holds up to DIV_W
  localparam int BUSY_W      = 7;   // busy percent field

  localparam int RATE_SCALE  = 1000; // ms -> s
  localparam int SCALE_SHIFT = 10;   // 2^10 > RATE_SCALE
  localparam int SCALE_W     = DIV_W + SCALE_SHIFT;
  localparam int PCT_SCALE   = 100;
  localparam int PCT_SHIFT   = 7;    // 2^7 > PCT_SCALE
  localparam int PCT_W       = DIV_W + PCT_SHIFT;
  localparam int TOT_W       = DIV_W + 1; // kernel + user tick sum

  typedef struct packed {
    logic [FIELD_W-1:0] now_ms;
    logic               net_valid;
    logic [FIELD_W-1:0] rx_count;
    logic [FIELD_W-1:0] tx_count;
    logic               source_changed;
    logic               cpu_valid;
    logic [FIELD_W-1:0] idle_time;
    logic [FIELD_W-1:0] kernel_time;
    logic [FIELD_W-1:0] user_time;
  } sample_t;

  typedef struct packed {
    logic [FIELD_W-1:0] rx_rate;
    logic [FIELD_W-1:0] tx_rate;
    logic [FIELD_W-1:0] rx_total;
    logic [FIELD_W-1:0] tx_total;
    logic [BUSY_W-1:0]  busy_percent;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_RX,
    ST_RX_WHOLE,
    ST_RX_SCALE,
    ST_CHK_TX,
    ST_TX_WHOLE,
    ST_TX_SCALE,
    ST_CHK_CPU,
    ST_CPU_DIV,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [2:0] {
    OP_RX_WHOLE,
    OP_RX_SCALE,
    OP_TX_WHOLE,
    OP_TX_SCALE,
    OP_BUSY
  } div_op_t;

  typedef struct packed {
    logic    prep;       // take a request, update baselines and totals
    logic    div_start;
    div_op_t div_op;
    logic    fin_rx;
    logic    fin_tx;
    logic    fin_busy;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic rx_go;
    logic tx_go;
    logic cpu_go;
    logic div_busy;
    logic div_done;
  } dp_status_t;

endpackage

### hw/rtl/cdrm_div.sv
// ----------------------------------------------------------------------------
// cdrm_div
// Serial restoring divider, one quotient bit per cycle. The caller preloads
// a partial remainder (must be below the divisor) and the left-aligned
// dividend bits still to shift in, plus the number of steps.
// ----------------------------------------------------------------------------
module cdrm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cdrm_pkg::DIV_W-1:0]  rem_init,
  input  logic [cdrm_pkg::DIV_W-1:0]  num_init,
  input  logic [cdrm_pkg::STEP_W-1:0] steps,
  input  logic [cdrm_pkg::DIV_W-1:0]  den,
  output logic                        busy,
  output logic                        done,
  output logic [cdrm_pkg::DIV_W-1:0]  quot,
  output logic [cdrm_pkg::DIV_W-1:0]  rem
);
  import cdrm_pkg::*;

  logic [STEP_W-1:0] cnt;
  logic [DIV_W-1:0]  nreg;
  logic [DIV_W-1:0]  den_r;
  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    diff;
  logic              fits;

  assign shifted = {rem, nreg[DIV_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      nreg  <= num_init;
      den_r <= den;
      quot  <= '0;
    end else if (busy) begin
      rem  <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      nreg <= nreg << 1;
      quot <= {quot[DIV_W-2:0], fits};
    end
  end

endmodule

### hw/rtl/cdrm_dp.sv
// ----------------------------------------------------------------------------
// cdrm_dp
// Datapath: baselines, saturating totals, elapsed time, counter deltas,
// CPU tick arithmetic, the shared divider and the result register.
// ----------------------------------------------------------------------------
module cdrm_dp #(
  parameter int COUNT_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cdrm_pkg::sample_t    sample,
  input  cdrm_pkg::dp_cmd_t    cmd,
  output cdrm_pkg::dp_status_t status,
  output cdrm_pkg::result_t    result
);
  import cdrm_pkg::*;

  localparam int CB = COUNT_BITS;
  localparam logic [CB-1:0]      CMAX       = '1;
  localparam logic [DIV_W-1:0]   CMAX_64    = DIV_W'(CMAX);
  localparam logic [DIV_W-1:0]   WHOLE_MAX  = CMAX_64 / RATE_SCALE;
  localparam logic [SCALE_W-1:0] CMAX_WIDE  = SCALE_W'(CMAX);

  // baselines and totals
  logic [FIELD_W-1:0] last_time;
  logic [CB-1:0]      prev_rx, prev_tx, sum_rx, sum_tx;
  logic [CB-1:0]      prev_idle, prev_kernel, prev_user;
  logic               net_base, cpu_base;

  // per-request work registers
  logic [DIV_W-1:0]   elapsed;
  logic [CB-1:0]      drx, dtx;
  logic               rx_go, tx_go, cpu_go;
  logic [DIV_W-1:0]   num_cpu, den_cpu;
  logic [SCALE_W-1:0] whole_scaled;
  logic               whole_ovf;
  logic [CB-1:0]      rx_rate, tx_rate;
  logic [BUSY_W-1:0]  busy_pct;

  // input view, counters taken modulo 2^CB
  logic [CB-1:0] rx_in, tx_in, idle_in, kern_in, user_in;
  assign rx_in   = sample.rx_count[CB-1:0];
  assign tx_in   = sample.tx_count[CB-1:0];
  assign idle_in = sample.idle_time[CB-1:0];
  assign kern_in = sample.kernel_time[CB-1:0];
  assign user_in = sample.user_time[CB-1:0];

  logic [DIV_W-1:0] elapsed_next;
  logic             net_ok, rx_take, tx_take;
  logic [CB-1:0]    drx_next, dtx_next;
  logic [CB:0]      rx_acc, tx_acc;
  logic [CB-1:0]    dk, du, di;
  logic [TOT_W-1:0] tot, bsy;
  logic             cpu_up, cpu_take;

  always_comb begin
    elapsed_next = (last_time != '0 && sample.now_ms > last_time) ?
                   sample.now_ms - last_time : '0;
    net_ok   = !sample.source_changed && net_base;
    rx_take  = sample.net_valid && net_ok && (rx_in >= prev_rx);
    tx_take  = sample.net_valid && net_ok && (tx_in >= prev_tx);
    drx_next = rx_in - prev_rx;
    dtx_next = tx_in - prev_tx;
    rx_acc   = {1'b0, sum_rx} + {1'b0, drx_next};
    tx_acc   = {1'b0, sum_tx} + {1'b0, dtx_next};

    dk  = kern_in - prev_kernel;
    du  = user_in - prev_user;
    di  = idle_in - prev_idle;
    tot = TOT_W'(dk) + TOT_W'(du);
    bsy = tot - TOT_W'(di);
    cpu_up   = (idle_in >= prev_idle) && (kern_in >= prev_kernel) &&
               (user_in >= prev_user);
    cpu_take = sample.cpu_valid && cpu_base && cpu_up &&
               (tot != '0) && (TOT_W'(di) <= tot);
  end

  // baselines, totals and work registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time   <= '0;
      prev_rx     <= '0;
      prev_tx     <= '0;
      sum_rx      <= '0;
      sum_tx      <= '0;
      prev_idle   <= '0;
      prev_kernel <= '0;
      prev_user   <= '0;
      net_base    <= 1'b0;
      cpu_base    <= 1'b0;
      rx_go       <= 1'b0;
      tx_go       <= 1'b0;
      cpu_go      <= 1'b0;
    end else if (cmd.prep) begin
      last_time <= sample.now_ms;
      rx_go     <= rx_take && (elapsed_next != '0);
      tx_go     <= tx_take && (elapsed_next != '0);
      cpu_go    <= cpu_take;
      if (!sample.net_valid) begin
        net_base <= 1'b0;
      end else begin
        if (rx_take) sum_rx <= rx_acc[CB] ? CMAX : rx_acc[CB-1:0];
        if (tx_take) sum_tx <= tx_acc[CB] ? CMAX : tx_acc[CB-1:0];
        prev_rx  <= rx_in;
        prev_tx  <= tx_in;
        net_base <= 1'b1;
      end
      if (!sample.cpu_valid) begin
        cpu_base <= 1'b0;
      end else begin
        prev_idle   <= idle_in;
        prev_kernel <= kern_in;
        prev_user   <= user_in;
        cpu_base    <= 1'b1;
      end
    end
  end

  // divider hookup
  logic                div_busy, div_done;
  logic [DIV_W-1:0]    div_quot, div_rem;
  logic [DIV_W-1:0]    d_rem_init, d_num_init, d_den;
  logic [STEP_W-1:0]   d_steps;
  logic [SCALE_W-1:0]  scale_prod;
  logic [PCT_W-1:0]    pct_prod;
  logic [SCALE_W-1:0]  rate_sum;
  logic [CB-1:0]       rate_fin;
  logic                scale_op;

  // partial remainder of the product is below the divisor, so only the low
  // product bits need shifting through the divider
  assign scale_prod = SCALE_W'(div_rem) * SCALE_W'(RATE_SCALE);
  assign pct_prod   = PCT_W'(num_cpu) * PCT_W'(PCT_SCALE);
  assign scale_op   = (cmd.div_op == OP_RX_SCALE) || (cmd.div_op == OP_TX_SCALE);
  assign rate_sum   = whole_scaled + SCALE_W'(div_quot);
  assign rate_fin   = (whole_ovf || rate_sum > CMAX_WIDE) ? CMAX : rate_sum[CB-1:0];

  always_comb begin
    d_rem_init = '0;
    d_num_init = '0;
    d_steps    = STEP_W'(CB);
    d_den      = elapsed;
    unique case (cmd.div_op)
      OP_RX_WHOLE: d_num_init = DIV_W'(drx) << (DIV_W - CB);
      OP_TX_WHOLE: d_num_init = DIV_W'(dtx) << (DIV_W - CB);
      OP_RX_SCALE, OP_TX_SCALE: begin
        d_rem_init = scale_prod[SCALE_W-1:SCALE_SHIFT];
        d_num_init = {scale_prod[SCALE_SHIFT-1:0], {(DIV_W-SCALE_SHIFT){1'b0}}};
        d_steps    = STEP_W'(SCALE_SHIFT);
      end
      OP_BUSY: begin
        d_rem_init = pct_prod[PCT_W-1:PCT_SHIFT];
        d_num_init = {pct_prod[PCT_SHIFT-1:0], {(DIV_W-PCT_SHIFT){1'b0}}};
        d_steps    = STEP_W'(PCT_SHIFT);
        d_den      = den_cpu;
      end
      default: d_num_init = '0;
    endcase
  end

  cdrm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .rem_init (d_rem_init),
    .num_init (d_num_init),
    .steps    (d_steps),
    .den      (d_den),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      elapsed  <= elapsed_next;
      drx      <= drx_next;
      dtx      <= dtx_next;
      // a 65-bit tick sum is halved on both sides
      num_cpu  <= bsy[TOT_W-1] || tot[TOT_W-1] ? bsy[TOT_W-1:1] : bsy[DIV_W-1:0];
      den_cpu  <= tot[TOT_W-1] ? tot[TOT_W-1:1] : tot[DIV_W-1:0];
      rx_rate  <= '0;
      tx_rate  <= '0;
      busy_pct <= '0;
    end else begin
      if (cmd.div_start && scale_op) begin
        whole_scaled <= SCALE_W'(div_quot) * SCALE_W'(RATE_SCALE);
        whole_ovf    <= div_quot > WHOLE_MAX;
      end
      if (cmd.fin_rx) rx_rate <= rate_fin;
      if (cmd.fin_tx) tx_rate <= rate_fin;
      if (cmd.fin_busy) begin
        busy_pct <= (div_quot > DIV_W'(PCT_SCALE)) ? BUSY_W'(PCT_SCALE) :
                    div_quot[BUSY_W-1:0];
      end
    end
    if (cmd.load_out) begin
      result.rx_rate      <= FIELD_W'(rx_rate);
      result.tx_rate      <= FIELD_W'(tx_rate);
      result.rx_total     <= FIELD_W'(sum_rx);
      result.tx_total     <= FIELD_W'(sum_tx);
      result.busy_percent <= busy_pct;
    end
  end

  assign status.rx_go    = rx_go;
  assign status.tx_go    = tx_go;
  assign status.cpu_go   = cpu_go;
  assign status.div_busy = div_busy;
  assign status.div_done = div_done;

endmodule

### hw/rtl/cdrm_ctrl.sv
// ----------------------------------------------------------------------------
// cdrm_ctrl
// Sequencer: takes a request, runs the rate and busy divisions that apply
// on the shared divider, then hands the result to the output register.
// ----------------------------------------------------------------------------
module cdrm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  cdrm_pkg::dp_status_t status,
  output cdrm_pkg::dp_cmd_t    cmd
);
  import cdrm_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out)    out_valid <= 1'b1;
      else if (out_ready)  out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_CHK_RX;
      ST_CHK_RX:   state_next = status.rx_go ? ST_RX_WHOLE : ST_CHK_TX;
      ST_RX_WHOLE: if (status.div_done) state_next = ST_RX_SCALE;
      ST_RX_SCALE: if (status.div_done) state_next = ST_CHK_TX;
      ST_CHK_TX:   state_next = status.tx_go ? ST_TX_WHOLE : ST_CHK_CPU;
      ST_TX_WHOLE: if (status.div_done) state_next = ST_TX_SCALE;
      ST_TX_SCALE: if (status.div_done) state_next = ST_CHK_CPU;
      ST_CHK_CPU:  state_next = status.cpu_go ? ST_CPU_DIV : ST_DONE;
      ST_CPU_DIV:  if (status.div_done) state_next = ST_DONE;
      ST_DONE:     if (!out_valid || out_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = (state == ST_IDLE);
    unique case (state)
      ST_IDLE:     cmd.prep = in_valid;
      ST_CHK_RX: begin
        cmd.div_start = status.rx_go;
        cmd.div_op    = OP_RX_WHOLE;
      end
      ST_RX_WHOLE: begin
        cmd.div_start = status.div_done;
        cmd.div_op    = OP_RX_SCALE;
      end
      ST_RX_SCALE: cmd.fin_rx = status.div_done;
      ST_CHK_TX: begin
        cmd.div_start = status.tx_go;
        cmd.div_op    = OP_TX_WHOLE;
      end
      ST_TX_WHOLE: begin
        cmd.div_start = status.div_done;
        cmd.div_op    = OP_TX_SCALE;
      end
      ST_TX_SCALE: cmd.fin_tx = status.div_done;
      ST_CHK_CPU: begin
        cmd.div_start = status.cpu_go;
        cmd.div_op    = OP_BUSY;
      end
      ST_CPU_DIV:  cmd.fin_busy = status.div_done;
      ST_DONE:     cmd.load_out = !out_valid || out_ready;
      default:     cmd = '0;
    endcase
  end

endmodule

### hw/rtl/counter_delta_rate_meter_core.sv
// ----------------------------------------------------------------------------
// counter_delta_rate_meter_core
// Turns one monitoring sample per request into rx/tx bytes per second,
// saturating byte totals and the CPU busy percentage.
// ----------------------------------------------------------------------------
// Usage:
//   sample/in_valid/in_ready carry one request: timestamp, rx/tx byte
//   counters and idle/kernel/user tick counters with their valid flags.
//   result/out_valid/out_ready return exactly one result per request.
//   The time from accept to out_valid is set by the single serial divider,
//   one quotient bit per cycle, which runs up to five divisions per request:
//   rx whole, rx remainder scale, tx whole, tx remainder scale and busy
//   percent. Skipped directions only pass through their check state.
//   Throughput: one request at a time; in_ready is high only while idle, so
//   the next request is taken in the cycle after the result is loaded.
//   The result sits in an output register, so the next request is taken
//   while an earlier result still waits for out_ready; a stalled receiver
//   only holds the block at the end of the following request.
//   Reset clears baselines, totals and both "have baseline" flags, so the
//   first valid sample after reset only sets the baseline and gives rate 0.
//   COUNT_BITS (16..64) is the counter width; counters wrap and rates and
//   totals saturate at that width.
// ----------------------------------------------------------------------------
module counter_delta_rate_meter_core #(
  parameter int COUNT_BITS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cdrm_pkg::sample_t sample,
  output logic              out_valid,
  input  logic              out_ready,
  output cdrm_pkg::result_t result
);
  import cdrm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: request accept, division order, output hand-off
  cdrm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // baselines, totals, divider and result register
  cdrm_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

  // the divider is never restarted mid-division
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.div_busy)
    else $error("divider started while busy");

  // a new request never lands while a division is in flight
  a_accept_div_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !status.div_busy)
    else $error("request accepted during division");

  // loading the output register always presents a result next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result load lost");

  // busy percent stays in range
  a_busy_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result.busy_percent <= BUSY_W'(PCT_SCALE)))
    else $error("busy percent above 100");

endmodule
